[design/i2cm_pkg.sv]
`timescale 1ns / 1ps
// shared constants and types for the i2c register transfer master
// no dependencies

package i2cm_pkg;

    // command codes of an input item
    localparam logic [1:0] CMD_TICK        = 2'd0;
    localparam logic [1:0] CMD_START_READ  = 2'd1;
    localparam logic [1:0] CMD_START_WRITE = 2'd2;
    localparam logic [1:0] CMD_LOAD        = 2'd3;

    // default write buffer depth
    localparam int WRITE_BUFFER_DEPTH_DEF = 16;

    // read bit of the device address byte
    localparam logic [7:0] ADDR_READ_BIT = 8'h01;

    // one result item
    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic [7:0] read_data;
        logic       read_valid;
        logic       busy_res;
        logic       done_res;
        logic       error;
    } result_t;

endpackage

[design/i2c_master_register_transfer.sv]
`timescale 1ns / 1ps
// top level of the i2c register transfer master: handshake, write buffer, result register
// depends on i2cm_pkg, i2cm_ram, i2cm_ctrl
//
//  channel | signals                                        | handshake
//  --------+------------------------------------------------+-------------------
//  input   | command dev_address reg_address byte_count     | in_valid/in_ready
//          | write_data buffer_index sda_sample             |
//  output  | scl_level sda_level read_data read_valid       | out_valid/out_ready
//          | busy_res done_res error                        |
//
// each accepted item steps the sequencer registers and the result register
// loads at the same edge, so an item can enter each cycle while in_ready is high
// in_ready drops only while a result waits and out_ready is low
// reset sets the sequencer's scl and sda registers high (bus released) and its phase
// idle and leaves the output empty; the write buffer is not cleared and needs no sweep
// a buffer slot is read through the registered ram port ahead of its use; a load that
// hits that slot in the same item is forwarded around the ram

module i2c_master_register_transfer #(
    parameter int WRITE_BUFFER_DEPTH = i2cm_pkg::WRITE_BUFFER_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] command,
    input  logic [7:0] dev_address,
    input  logic [7:0] reg_address,
    input  logic [7:0] byte_count,
    input  logic [7:0] write_data,
    input  logic [3:0] buffer_index,
    input  logic       sda_sample,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       scl_level,
    output logic       sda_level,
    output logic [7:0] read_data,
    output logic       read_valid,
    output logic       busy_res,
    output logic       done_res,
    output logic       error
);

    localparam int AW = (WRITE_BUFFER_DEPTH > 1) ? $clog2(WRITE_BUFFER_DEPTH) : 1;

    logic              accept;
    logic              load_en;
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     rd_addr;
    logic [7:0]        ram_rdata;
    logic [7:0]        buf_byte;
    i2cm_pkg::result_t res_next;
    i2cm_pkg::result_t res_reg;
    logic              out_valid_reg;

    // result register frees up when taken, so input keeps flowing
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // slots beyond the buffer depth are dropped
    assign load_en = accept && (command == i2cm_pkg::CMD_LOAD) &&
                     (int'(buffer_index) < WRITE_BUFFER_DEPTH);
    assign wr_addr = AW'(buffer_index);

    i2cm_ram #(
        .WIDTH (8),
        .DEPTH (WRITE_BUFFER_DEPTH)
    ) u_wbuf (
        .clk   (clk),
        .we    (load_en),
        .waddr (wr_addr),
        .wdata (write_data),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // a load in this same item takes effect before the slot is read
    assign buf_byte = (load_en && (wr_addr == rd_addr)) ? write_data : ram_rdata;

    i2cm_ctrl #(
        .DEPTH (WRITE_BUFFER_DEPTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .step_en     (accept),
        .command     (command),
        .dev_address (dev_address),
        .reg_address (reg_address),
        .byte_count  (byte_count),
        .sda_sample  (sda_sample),
        .buf_byte    (buf_byte),
        .rd_addr     (rd_addr),
        .res_next    (res_next)
    );

    // output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload, held while the output stalls
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign scl_level  = res_reg.scl_level;
    assign sda_level  = res_reg.sda_level;
    assign read_data  = res_reg.read_data;
    assign read_valid = res_reg.read_valid;
    assign busy_res   = res_reg.busy_res;
    assign done_res   = res_reg.done_res;
    assign error      = res_reg.error;

    // a finished transaction is never still busy
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> !busy_res)
        else $error("done reported while still busy");

    // an error only comes with the end of a transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error |-> done_res)
        else $error("error without done");

    // a received byte completes on a raised clock inside a transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && read_valid |-> busy_res && scl_level)
        else $error("read byte outside an scl high phase");

    // a stalled result blocks the input so nothing is overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(res_reg))
        else $error("stalled result changed");

endmodule

[design/i2cm_ram.sv]
`timescale 1ns / 1ps
// generic single write port ram with registered read, write-first on collision
// no dependencies

module i2cm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (we && (waddr == raddr))
        begin
            rdata <= wdata;
        end
        else
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[design/i2cm_ctrl.sv]
`timescale 1ns / 1ps
// bus sequencer: at most one line write per accepted item, state held in registers
// depends on i2cm_pkg

module i2cm_ctrl #(
    parameter int DEPTH = i2cm_pkg::WRITE_BUFFER_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step_en,
    input  logic [1:0]            command,
    input  logic [7:0]            dev_address,
    input  logic [7:0]            reg_address,
    input  logic [7:0]            byte_count,
    input  logic                  sda_sample,
    input  logic [7:0]            buf_byte,
    output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output i2cm_pkg::result_t     res_next
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [3:0] {
        P_IDLE,
        P_START,
        P_TX_DEV,
        P_ACK_DEV,
        P_TX_REG,
        P_ACK_REG,
        P_RESTART,
        P_TX_DEVR,
        P_ACK_DEVR,
        P_TX_DATA,
        P_ACK_DATA,
        P_RX_REL,
        P_RX_BIT,
        P_TX_ACK,
        P_STOP
    } phase_t;

    phase_t        phase_reg, phase_next;
    logic [1:0]    line_step_reg, line_step_next;
    logic [2:0]    bit_cnt_reg, bit_cnt_next;
    logic [7:0]    byte_cnt_reg, byte_cnt_next;
    logic [7:0]    shift_reg, shift_next;
    logic [7:0]    dev_reg, dev_next;
    logic [7:0]    regaddr_reg, regaddr_next;
    logic [7:0]    len_reg, len_next;
    logic          is_read_reg, is_read_next;
    logic          scl_reg, scl_next;
    logic          sda_reg, sda_next;
    logic [AW-1:0] ptr_reg, ptr_next;

    logic [AW-1:0] ptr_inc;
    logic [8:0]    byte_inc;
    logic [7:0]    rx_shift;
    logic          last_byte;
    logic          rv;
    logic [7:0]    rd;
    logic          fin;
    logic          err;

    assign ptr_inc   = (ptr_reg == AW'(DEPTH - 1)) ? '0 : ptr_reg + AW'(1);
    assign byte_inc  = {1'b0, byte_cnt_reg} + 9'd1;
    assign last_byte = (byte_inc >= {1'b0, len_reg});
    assign rx_shift  = {shift_reg[6:0], sda_sample};

    // buffer slot needed when the current acknowledge closes
    assign rd_addr = (phase_reg == P_ACK_DATA) ? ptr_inc : ptr_reg;

    always_comb
    begin
        phase_next     = phase_reg;
        line_step_next = line_step_reg;
        bit_cnt_next   = bit_cnt_reg;
        byte_cnt_next  = byte_cnt_reg;
        shift_next     = shift_reg;
        dev_next       = dev_reg;
        regaddr_next   = regaddr_reg;
        len_next       = len_reg;
        is_read_next   = is_read_reg;
        scl_next       = scl_reg;
        sda_next       = sda_reg;
        ptr_next       = ptr_reg;
        rv             = 1'b0;
        rd             = 8'd0;
        fin            = 1'b0;
        err            = 1'b0;

        if (phase_reg == P_IDLE)
        begin
            if ((command == i2cm_pkg::CMD_START_READ) ||
                (command == i2cm_pkg::CMD_START_WRITE))
            begin
                is_read_next   = (command == i2cm_pkg::CMD_START_READ);
                dev_next       = dev_address;
                regaddr_next   = reg_address;
                len_next       = ((command == i2cm_pkg::CMD_START_READ) &&
                                  (byte_count == 8'd0)) ? 8'd1 : byte_count;
                byte_cnt_next  = 8'd0;
                bit_cnt_next   = 3'd0;
                ptr_next       = '0;
                phase_next     = P_START;
                line_step_next = 2'd0;
            end
        end
        else
        begin
            case (phase_reg)
                P_START, P_RESTART:
                begin
                    case (line_step_reg)
                        2'd0:
                        begin
                            sda_next       = 1'b1;
                            line_step_next = 2'd1;
                        end
                        2'd1:
                        begin
                            scl_next       = 1'b1;
                            line_step_next = 2'd2;
                        end
                        2'd2:
                        begin
                            sda_next       = 1'b0;
                            line_step_next = 2'd3;
                        end
                        default:
                        begin
                            scl_next       = 1'b0;
                            line_step_next = 2'd0;
                            bit_cnt_next   = 3'd0;
                            if (phase_reg == P_START)
                            begin
                                phase_next = P_TX_DEV;
                                shift_next = dev_reg;
                            end
                            else
                            begin
                                phase_next = P_TX_DEVR;
                                shift_next = dev_reg | i2cm_pkg::ADDR_READ_BIT;
                            end
                        end
                    endcase
                end
                P_TX_DEV, P_TX_REG, P_TX_DEVR, P_TX_DATA:
                begin
                    case (line_step_reg)
                        2'd0:
                        begin
                            sda_next       = shift_reg[3'd7 - bit_cnt_reg];
                            line_step_next = 2'd1;
                        end
                        2'd1:
                        begin
                            scl_next       = 1'b1;
                            line_step_next = 2'd2;
                        end
                        default:
                        begin
                            scl_next       = 1'b0;
                            line_step_next = 2'd0;
                            if (bit_cnt_reg == 3'd7)
                            begin
                                bit_cnt_next = 3'd0;
                                case (phase_reg)
                                    P_TX_DEV:  phase_next = P_ACK_DEV;
                                    P_TX_REG:  phase_next = P_ACK_REG;
                                    P_TX_DEVR: phase_next = P_ACK_DEVR;
                                    default:   phase_next = P_ACK_DATA;
                                endcase
                            end
                            else
                            begin
                                bit_cnt_next = bit_cnt_reg + 3'd1;
                            end
                        end
                    endcase
                end
                P_ACK_DEV, P_ACK_REG, P_ACK_DEVR, P_ACK_DATA:
                begin
                    case (line_step_reg)
                        2'd0:
                        begin
                            sda_next       = 1'b1;
                            line_step_next = 2'd1;
                        end
                        2'd1:
                        begin
                            scl_next       = 1'b1;
                            shift_next     = {7'd0, sda_sample};
                            line_step_next = 2'd2;
                        end
                        default:
                        begin
                            scl_next       = 1'b0;
                            line_step_next = 2'd0;
                            if (shift_reg != 8'd0)
                            begin
                                // not acknowledged: end without stop
                                phase_next = P_IDLE;
                                fin        = 1'b1;
                                err        = 1'b1;
                            end
                            else
                            begin
                                case (phase_reg)
                                    P_ACK_DEV:
                                    begin
                                        phase_next   = P_TX_REG;
                                        bit_cnt_next = 3'd0;
                                        shift_next   = regaddr_reg;
                                    end
                                    P_ACK_REG:
                                    begin
                                        if (is_read_reg)
                                        begin
                                            phase_next = P_RESTART;
                                        end
                                        else if (len_reg == 8'd0)
                                        begin
                                            phase_next = P_STOP;
                                        end
                                        else
                                        begin
                                            byte_cnt_next = 8'd0;
                                            ptr_next      = '0;
                                            phase_next    = P_TX_DATA;
                                            bit_cnt_next  = 3'd0;
                                            shift_next    = buf_byte;
                                        end
                                    end
                                    P_ACK_DEVR:
                                    begin
                                        byte_cnt_next = 8'd0;
                                        phase_next    = P_RX_REL;
                                    end
                                    default:
                                    begin
                                        byte_cnt_next = byte_inc[7:0];
                                        ptr_next      = ptr_inc;
                                        if (last_byte)
                                        begin
                                            phase_next = P_STOP;
                                        end
                                        else
                                        begin
                                            phase_next   = P_TX_DATA;
                                            bit_cnt_next = 3'd0;
                                            shift_next   = buf_byte;
                                        end
                                    end
                                endcase
                            end
                        end
                    endcase
                end
                P_RX_REL:
                begin
                    sda_next       = 1'b1;
                    phase_next     = P_RX_BIT;
                    line_step_next = 2'd0;
                    bit_cnt_next   = 3'd0;
                    shift_next     = 8'd0;
                end
                P_RX_BIT:
                begin
                    if (line_step_reg == 2'd0)
                    begin
                        scl_next       = 1'b1;
                        shift_next     = rx_shift;
                        line_step_next = 2'd1;
                        if (bit_cnt_reg == 3'd7)
                        begin
                            rv = 1'b1;
                            rd = rx_shift;
                        end
                    end
                    else
                    begin
                        scl_next       = 1'b0;
                        line_step_next = 2'd0;
                        if (bit_cnt_reg == 3'd7)
                        begin
                            bit_cnt_next = 3'd0;
                            phase_next   = P_TX_ACK;
                        end
                        else
                        begin
                            bit_cnt_next = bit_cnt_reg + 3'd1;
                        end
                    end
                end
                P_TX_ACK:
                begin
                    case (line_step_reg)
                        2'd0:
                        begin
                            sda_next       = last_byte;
                            line_step_next = 2'd1;
                        end
                        2'd1:
                        begin
                            scl_next       = 1'b1;
                            line_step_next = 2'd2;
                        end
                        default:
                        begin
                            scl_next       = 1'b0;
                            line_step_next = 2'd0;
                            if (last_byte)
                            begin
                                phase_next = P_STOP;
                            end
                            else
                            begin
                                byte_cnt_next = byte_inc[7:0];
                                phase_next    = P_RX_REL;
                            end
                        end
                    endcase
                end
                P_STOP:
                begin
                    case (line_step_reg)
                        2'd0:
                        begin
                            sda_next       = 1'b0;
                            line_step_next = 2'd1;
                        end
                        2'd1:
                        begin
                            scl_next       = 1'b1;
                            line_step_next = 2'd2;
                        end
                        default:
                        begin
                            sda_next       = 1'b1;
                            line_step_next = 2'd0;
                            phase_next     = P_IDLE;
                            fin            = 1'b1;
                        end
                    endcase
                end
                default:
                begin
                    phase_next     = P_IDLE;
                    line_step_next = 2'd0;
                end
            endcase
        end
    end

    always_comb
    begin
        res_next.scl_level  = scl_next;
        res_next.sda_level  = sda_next;
        res_next.read_data  = rd;
        res_next.read_valid = rv;
        res_next.busy_res   = (phase_next != P_IDLE);
        res_next.done_res   = fin;
        res_next.error      = err;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= P_IDLE;
            line_step_reg <= 2'd0;
            bit_cnt_reg   <= 3'd0;
            byte_cnt_reg  <= 8'd0;
            shift_reg     <= 8'd0;
            dev_reg       <= 8'd0;
            regaddr_reg   <= 8'd0;
            len_reg       <= 8'd0;
            is_read_reg   <= 1'b0;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            ptr_reg       <= '0;
        end
        else if (step_en)
        begin
            phase_reg     <= phase_next;
            line_step_reg <= line_step_next;
            bit_cnt_reg   <= bit_cnt_next;
            byte_cnt_reg  <= byte_cnt_next;
            shift_reg     <= shift_next;
            dev_reg       <= dev_next;
            regaddr_reg   <= regaddr_next;
            len_reg       <= len_next;
            is_read_reg   <= is_read_next;
            scl_reg       <= scl_next;
            sda_reg       <= sda_next;
            ptr_reg       <= ptr_next;
        end
    end

endmodule
